/* rtl/core/sot_pkg.sv */
`default_nettype none

package sot_pkg;

    // Default coordinate width: Q12.4 fixed point.
    localparam int COORD_WIDTH_DEF = 16;

    // One lane for each corner of a rectangle.
    localparam int NUM_CORNERS = 4;

    // Test selected by the mode field. Codes five to seven select no test.
    typedef enum logic [2:0] {
        MODE_PT_RECT   = 3'd0,
        MODE_RECT_RECT = 3'd1,
        MODE_PT_CIRC   = 3'd2,
        MODE_CIRC_CIRC = 3'd3,
        MODE_CIRC_RECT = 3'd4
    } t_mode;

    // Per-request verdict flags carried down the pipeline.
    typedef struct packed {
        logic direct;   // hit already decided by the edge compares
        logic circ;     // hit decided by the squared-distance lanes
    } t_ctl;

endpackage : sot_pkg

`default_nettype wire

/* rtl/core/sot_geom.sv */
`default_nettype none

module sot_geom
    import sot_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_vld,
    output logic                          o_rdy,
    input  wire logic [2:0]               i_mode,
    input  wire logic [COORD_WIDTH-1:0]   i_a_x,
    input  wire logic [COORD_WIDTH-1:0]   i_a_y,
    input  wire logic [COORD_WIDTH-1:0]   i_a_width,
    input  wire logic [COORD_WIDTH-1:0]   i_a_height,
    input  wire logic [COORD_WIDTH-2:0]   i_a_radius,
    input  wire logic [COORD_WIDTH-1:0]   i_b_x,
    input  wire logic [COORD_WIDTH-1:0]   i_b_y,
    input  wire logic [COORD_WIDTH-1:0]   i_b_width,
    input  wire logic [COORD_WIDTH-1:0]   i_b_height,
    input  wire logic [COORD_WIDTH-2:0]   i_b_radius,
    input  wire logic                     i_rdy,
    output logic                          o_vld,
    output t_ctl                          o_ctl,
    output logic [COORD_WIDTH+1:0]        o_dx [NUM_CORNERS],
    output logic [COORD_WIDTH+1:0]        o_dy [NUM_CORNERS],
    output logic [COORD_WIDTH:0]          o_rad2
);

    // All coordinates are in doubled units; edges need two bits over the field.
    localparam int E = COORD_WIDTH + 2;

    // Stage one: doubled centres, box edges and doubled radius.
    logic                 r_v1, n_v1;
    t_mode                r_mode1;
    logic signed [E-1:0]  r_ax2, r_ay2, r_bx2, r_by2;
    logic signed [E-1:0]  r_al, r_ar, r_at, r_ab;
    logic signed [E-1:0]  r_bl, r_br, r_bt, r_bb;
    logic [COORD_WIDTH:0] r_rad2a;

    logic signed [E-1:0]  n_ax2, n_ay2, n_bx2, n_by2;
    logic signed [E-1:0]  n_aw, n_ah, n_bw, n_bh;
    logic [COORD_WIDTH-1:0] n_rsum;
    logic [COORD_WIDTH:0] n_rad2a;
    logic                 en1, en2;

    // Stage two: verdict flags and per-lane distances.
    logic                 r_v2, n_v2;
    t_ctl                 r_ctl, n_ctl;
    logic [E-1:0]         r_dx [NUM_CORNERS];
    logic [E-1:0]         r_dy [NUM_CORNERS];
    logic [COORD_WIDTH:0] r_rad2b;

    logic                 ptin_x, ptin_y, ovl;
    logic signed [E-1:0]  lane_px [NUM_CORNERS];
    logic signed [E-1:0]  lane_py [NUM_CORNERS];
    logic signed [E:0]    diff_x  [NUM_CORNERS];
    logic signed [E:0]    diff_y  [NUM_CORNERS];
    logic [E:0]           mag_x   [NUM_CORNERS];
    logic [E:0]           mag_y   [NUM_CORNERS];

    assign en2   = ~r_v2 | i_rdy;
    assign en1   = ~r_v1 | en2;
    assign o_rdy = en1;
    assign n_v1  = en1 ? i_vld : r_v1;
    assign n_v2  = en2 ? r_v1 : r_v2;

    always_comb begin
        n_ax2  = $signed({i_a_x[COORD_WIDTH-1], i_a_x, 1'b0});
        n_ay2  = $signed({i_a_y[COORD_WIDTH-1], i_a_y, 1'b0});
        n_bx2  = $signed({i_b_x[COORD_WIDTH-1], i_b_x, 1'b0});
        n_by2  = $signed({i_b_y[COORD_WIDTH-1], i_b_y, 1'b0});
        n_bw   = $signed({2'b00, i_b_width});
        n_bh   = $signed({2'b00, i_b_height});
        n_rsum = {1'b0, i_a_radius} + {1'b0, i_b_radius};
        if (t_mode'(i_mode) == MODE_CIRC_RECT) begin
            // The circle stands in as a square of side twice the radius.
            n_aw = $signed({2'b00, i_a_radius, 1'b0});
            n_ah = $signed({2'b00, i_a_radius, 1'b0});
        end else begin
            n_aw = $signed({2'b00, i_a_width});
            n_ah = $signed({2'b00, i_a_height});
        end
        if (t_mode'(i_mode) == MODE_CIRC_CIRC) begin
            n_rad2a = {n_rsum, 1'b0};
        end else begin
            n_rad2a = {1'b0, i_a_radius, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_mode1 <= t_mode'(i_mode);
            r_ax2   <= n_ax2;
            r_ay2   <= n_ay2;
            r_bx2   <= n_bx2;
            r_by2   <= n_by2;
            r_al    <= n_ax2 - n_aw;
            r_ar    <= n_ax2 + n_aw;
            r_at    <= n_ay2 - n_ah;
            r_ab    <= n_ay2 + n_ah;
            r_bl    <= n_bx2 - n_bw;
            r_br    <= n_bx2 + n_bw;
            r_bt    <= n_by2 - n_bh;
            r_bb    <= n_by2 + n_bh;
            r_rad2a <= n_rad2a;
        end
    end

    always_comb begin
        ptin_x = (r_ax2 > r_bl) && (r_ax2 < r_br);
        ptin_y = (r_ay2 > r_bt) && (r_ay2 < r_bb);
        ovl    = (r_ar > r_bl) && (r_al < r_br) && (r_ab > r_bt) && (r_at < r_bb);

        // Corner order: left-top, right-top, left-bottom, right-bottom.
        lane_px[0] = r_bl;
        lane_py[0] = r_bt;
        lane_px[1] = r_br;
        lane_py[1] = r_bt;
        lane_px[2] = r_bl;
        lane_py[2] = r_bb;
        lane_px[3] = r_br;
        lane_py[3] = r_bb;
        if (r_mode1 != MODE_CIRC_RECT) begin
            for (int k = 0; k < NUM_CORNERS; k++) begin
                lane_px[k] = r_bx2;
                lane_py[k] = r_by2;
            end
        end
        for (int k = 0; k < NUM_CORNERS; k++) begin
            diff_x[k] = {r_ax2[E-1], r_ax2} - {lane_px[k][E-1], lane_px[k]};
            diff_y[k] = {r_ay2[E-1], r_ay2} - {lane_py[k][E-1], lane_py[k]};
            mag_x[k]  = diff_x[k][E] ? -diff_x[k] : diff_x[k];
            mag_y[k]  = diff_y[k][E] ? -diff_y[k] : diff_y[k];
        end

        n_ctl = '0;
        case (r_mode1)
            MODE_PT_RECT: begin
                n_ctl.direct = ptin_x && ptin_y;
            end
            MODE_RECT_RECT: begin
                n_ctl.direct = ovl;
            end
            MODE_PT_CIRC, MODE_CIRC_CIRC: begin
                n_ctl.circ = 1'b1;
            end
            MODE_CIRC_RECT: begin
                // Centre within a band: square test; otherwise corner tests.
                n_ctl.direct = (ptin_x || ptin_y) && ovl;
                n_ctl.circ   = !(ptin_x || ptin_y);
            end
            default: begin
                n_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_ctl   <= n_ctl;
            r_rad2b <= r_rad2a;
            for (int k = 0; k < NUM_CORNERS; k++) begin
                r_dx[k] <= mag_x[k][E-1:0];
                r_dy[k] <= mag_y[k][E-1:0];
            end
        end
    end

    assign o_vld  = r_v2;
    assign o_ctl  = r_ctl;
    assign o_dx   = r_dx;
    assign o_dy   = r_dy;
    assign o_rad2 = r_rad2b;

endmodule : sot_geom

`default_nettype wire

/* rtl/core/sot_square.sv */
`default_nettype none

module sot_square
    import sot_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_vld,
    output logic                            o_rdy,
    input  t_ctl                            i_ctl,
    input  wire logic [COORD_WIDTH+1:0]     i_dx [NUM_CORNERS],
    input  wire logic [COORD_WIDTH+1:0]     i_dy [NUM_CORNERS],
    input  wire logic [COORD_WIDTH:0]       i_rad2,
    input  wire logic                       i_rdy,
    output logic                            o_vld,
    output t_ctl                            o_ctl,
    output logic [2*COORD_WIDTH+3:0]        o_dx2 [NUM_CORNERS],
    output logic [2*COORD_WIDTH+3:0]        o_dy2 [NUM_CORNERS],
    output logic [2*COORD_WIDTH+1:0]        o_r2
);

    logic                      r_v, n_v, en;
    t_ctl                      r_ctl;
    logic [2*COORD_WIDTH+3:0]  r_dx2 [NUM_CORNERS];
    logic [2*COORD_WIDTH+3:0]  r_dy2 [NUM_CORNERS];
    logic [2*COORD_WIDTH+1:0]  r_r2;

    assign en    = ~r_v | i_rdy;
    assign o_rdy = en;
    assign n_v   = en ? i_vld : r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
    end

    // Nine independent squarers, one per distance component plus the radius.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctl <= i_ctl;
            r_r2  <= i_rad2 * i_rad2;
            for (int k = 0; k < NUM_CORNERS; k++) begin
                r_dx2[k] <= i_dx[k] * i_dx[k];
                r_dy2[k] <= i_dy[k] * i_dy[k];
            end
        end
    end

    assign o_vld = r_v;
    assign o_ctl = r_ctl;
    assign o_dx2 = r_dx2;
    assign o_dy2 = r_dy2;
    assign o_r2  = r_r2;

endmodule : sot_square

`default_nettype wire

/* rtl/core/sot_decide.sv */
`default_nettype none

module sot_decide
    import sot_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_vld,
    output logic                            o_rdy,
    input  t_ctl                            i_ctl,
    input  wire logic [2*COORD_WIDTH+3:0]   i_dx2 [NUM_CORNERS],
    input  wire logic [2*COORD_WIDTH+3:0]   i_dy2 [NUM_CORNERS],
    input  wire logic [2*COORD_WIDTH+1:0]   i_r2,
    input  wire logic                       i_rdy,
    output logic                            o_vld,
    output logic                            o_hit
);

    localparam int SW = 2 * COORD_WIDTH + 5;

    logic              r_v, n_v, en;
    logic              r_hit, n_hit;
    logic [SW-1:0]     sq_sum [NUM_CORNERS];
    logic [SW-1:0]     r2_ext;
    logic              any_in;

    assign en    = ~r_v | i_rdy;
    assign o_rdy = en;
    assign n_v   = en ? i_vld : r_v;

    always_comb begin
        r2_ext = {3'b000, i_r2};
        any_in = 1'b0;
        for (int k = 0; k < NUM_CORNERS; k++) begin
            sq_sum[k] = {1'b0, i_dx2[k]} + {1'b0, i_dy2[k]};
            any_in    = any_in | (r2_ext > sq_sum[k]);
        end
        n_hit = i_ctl.direct | (i_ctl.circ & any_in);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit <= n_hit;
        end
    end

    assign o_vld = r_v;
    assign o_hit = r_hit;

endmodule : sot_decide

`default_nettype wire

/* rtl/core/shape_overlap_test.sv */
`default_nettype none

// Shape overlap test. Each request carries one pair of shapes in Q12.4 fixed
// point and a mode in tuser that picks the test: point in rectangle, rectangle
// against rectangle, point in circle, circle against circle, or circle against
// rectangle; the remaining mode codes always answer with no hit. Rectangles are
// given as centre and size and are worked in doubled units so their half-size
// edges stay exact. All comparisons are strict, and circle tests compare
// squared distances against the squared radius. Every request yields exactly
// one result byte whose lowest bit is the hit flag. The block accepts one
// request per clock cycle while its output is not stalled; each request
// passes through four register stages: edge arithmetic, edge compares and
// distance magnitudes, the squaring multipliers, and the final sum and
// compare that also serves as the output register. Each stage advances
// whenever it is empty or the stage after it moves, so a stalled output holds
// its result and pipeline bubbles are squeezed out behind it.

module shape_overlap_test
    import sot_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // Fields from bit 0 up: a_x, a_y, a_width, a_height, a_radius,
    // b_x, b_y, b_width, b_height, b_radius, then zero fill.
    input  wire logic [((10*COORD_WIDTH-2+7)/8)*8-1:0] i_s_axis_tdata,
    // Fields from bit 0 up: mode.
    input  wire logic [2:0]            i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // Fields from bit 0 up: hit, then zero fill.
    output logic [7:0]                 o_m_axis_tdata
);

    localparam int W = COORD_WIDTH;

    // Bit offsets of the request fields inside tdata.
    localparam int OFF_AX = 0;
    localparam int OFF_AY = OFF_AX + W;
    localparam int OFF_AW = OFF_AY + W;
    localparam int OFF_AH = OFF_AW + W;
    localparam int OFF_AR = OFF_AH + W;
    localparam int OFF_BX = OFF_AR + W - 1;
    localparam int OFF_BY = OFF_BX + W;
    localparam int OFF_BW = OFF_BY + W;
    localparam int OFF_BH = OFF_BW + W;
    localparam int OFF_BR = OFF_BH + W;

    // Handshake between stage groups: ready flows upstream, valid downstream.
    logic              geo_vld, sq_vld, dec_vld;
    logic              sq_rdy, dec_rdy;
    logic              hit;
    t_ctl              geo_ctl, sq_ctl;
    logic [W+1:0]      geo_dx  [NUM_CORNERS];
    logic [W+1:0]      geo_dy  [NUM_CORNERS];
    logic [W:0]        geo_rad2;
    logic [2*W+3:0]    sq_dx2  [NUM_CORNERS];
    logic [2*W+3:0]    sq_dy2  [NUM_CORNERS];
    logic [2*W+1:0]    sq_r2;

    // Stages one and two: doubled edges, strict compares, distance magnitudes
    // from the circle centre to the point or to each rectangle corner.
    sot_geom #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_geom (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (i_s_axis_tvalid),
        .o_rdy      (o_s_axis_tready),
        .i_mode     (i_s_axis_tuser),
        .i_a_x      (i_s_axis_tdata[OFF_AX +: W]),
        .i_a_y      (i_s_axis_tdata[OFF_AY +: W]),
        .i_a_width  (i_s_axis_tdata[OFF_AW +: W]),
        .i_a_height (i_s_axis_tdata[OFF_AH +: W]),
        .i_a_radius (i_s_axis_tdata[OFF_AR +: W-1]),
        .i_b_x      (i_s_axis_tdata[OFF_BX +: W]),
        .i_b_y      (i_s_axis_tdata[OFF_BY +: W]),
        .i_b_width  (i_s_axis_tdata[OFF_BW +: W]),
        .i_b_height (i_s_axis_tdata[OFF_BH +: W]),
        .i_b_radius (i_s_axis_tdata[OFF_BR +: W-1]),
        .i_rdy      (sq_rdy),
        .o_vld      (geo_vld),
        .o_ctl      (geo_ctl),
        .o_dx       (geo_dx),
        .o_dy       (geo_dy),
        .o_rad2     (geo_rad2)
    );

    // Stage three: squares of every distance component and of the radius.
    sot_square #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (geo_vld),
        .o_rdy   (sq_rdy),
        .i_ctl   (geo_ctl),
        .i_dx    (geo_dx),
        .i_dy    (geo_dy),
        .i_rad2  (geo_rad2),
        .i_rdy   (dec_rdy),
        .o_vld   (sq_vld),
        .o_ctl   (sq_ctl),
        .o_dx2   (sq_dx2),
        .o_dy2   (sq_dy2),
        .o_r2    (sq_r2)
    );

    // Stage four: squared-distance sums against the squared radius, final
    // verdict, held in the output register until the consumer takes it.
    sot_decide #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (sq_vld),
        .o_rdy   (dec_rdy),
        .i_ctl   (sq_ctl),
        .i_dx2   (sq_dx2),
        .i_dy2   (sq_dy2),
        .i_r2    (sq_r2),
        .i_rdy   (i_m_axis_tready),
        .o_vld   (dec_vld),
        .o_hit   (hit)
    );

    assign o_m_axis_tvalid = dec_vld;
    assign o_m_axis_tdata  = {7'b0000000, hit};

endmodule : shape_overlap_test

`default_nettype wire

/* sim/tb_shape_overlap_test.sv */
`timescale 1ns / 1ps

// Testbench for the shape overlap test. Requests carry a pair of shapes in
// Q12.4 fixed point and a mode in tuser; every request returns one byte
// whose lowest bit is the hit flag. The bench keeps its own predictor of
// the overlap tests, computed on 64-bit integers in doubled units so that
// half-size rectangle edges stay exact, and checks each returned byte
// against the oldest prediction still waiting. A short directed part covers
// every mode, touching edges, zero sizes and the coordinate extremes; a
// long random part follows with idling on both stream sides at several
// levels of pressure.

module tb_shape_overlap_test;
    import sot_pkg::*;

    localparam int CW           = COORD_WIDTH_DEF;
    localparam int TDATA_W      = ((10 * CW - 2 + 7) / 8) * 8;
    // Far above the slowest legal run: about 800 requests, each behind a
    // long sender gap and a long receiver stall.
    localparam int CYCLE_LIMIT  = 200000;
    // Four pipeline stages, plus some margin to catch stray results.
    localparam int DRAIN_CYCLES = 12;

    // One request: both shapes and the selected test. Signed fields are
    // declared signed so that they sign-extend into the predictor's math.
    typedef struct {
        logic [2:0]           mode;
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic [CW-1:0]        aw;
        logic [CW-1:0]        ah;
        logic [CW-2:0]        ar;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic [CW-1:0]        bw;
        logic [CW-1:0]        bh;
        logic [CW-2:0]        br;
    } shape_pair_t;

    // Rectangle edges in doubled units: left, right, top and bottom.
    typedef struct {
        longint l;
        longint r;
        longint t;
        longint b;
    } rect_edges_t;

    logic               i_clk    = 1'b0;
    logic               i_rst_n  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic [2:0]         s_tuser  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [7:0]         m_tdata;

    // Hit flags predicted for requests that were accepted but not yet answered.
    bit          pending_hits[$];
    int          error_count = 0;
    int          cycle_count = 0;
    // 0 means no idling at all, 1 light idling, 2 heavy idling.
    int          idle_level  = 0;
    int unsigned stall_left  = 0;

    always #10 i_clk = ~i_clk;

    shape_overlap_test #(
        .COORD_WIDTH (CW)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Edges of a rectangle given by centre and full size, in doubled units.
    function automatic rect_edges_t edges_of(longint x, longint y, longint w, longint h);
        rect_edges_t e;
        e.l = 2 * x - w;
        e.r = 2 * x + w;
        e.t = 2 * y - h;
        e.b = 2 * y + h;
        return e;
    endfunction

    function automatic bit edges_overlap(rect_edges_t a, rect_edges_t b);
        return a.r > b.l && a.l < b.r && a.b > b.t && a.t < b.b;
    endfunction

    // Everything in doubled units, so rad2 is twice the radius. The largest
    // squares stay well inside 64 bits, so plain longint math is exact.
    function automatic bit point_in_circle(longint cx, longint cy, longint rad2,
                                           longint px, longint py);
        longint dx;
        longint dy;
        dx = (cx > px) ? cx - px : px - cx;
        dy = (cy > py) ? cy - py : py - cy;
        return rad2 * rad2 > dx * dx + dy * dy;
    endfunction

    function automatic bit predict_hit(shape_pair_t p);
        longint      ax;
        longint      ay;
        longint      ar;
        longint      br;
        longint      px;
        longint      py;
        rect_edges_t rect_b;
        bit          hit;
        ax     = p.ax;
        ay     = p.ay;
        ar     = p.ar;
        br     = p.br;
        px     = 2 * ax;
        py     = 2 * ay;
        rect_b = edges_of(p.bx, p.by, p.bw, p.bh);
        hit    = 1'b0;
        case (p.mode)
            MODE_PT_RECT: begin
                hit = px > rect_b.l && px < rect_b.r && py > rect_b.t && py < rect_b.b;
            end
            MODE_RECT_RECT: begin
                hit = edges_overlap(edges_of(ax, ay, p.aw, p.ah), rect_b);
            end
            MODE_PT_CIRC: begin
                hit = point_in_circle(px, py, 2 * ar, 2 * longint'(p.bx),
                                      2 * longint'(p.by));
            end
            MODE_CIRC_CIRC: begin
                hit = point_in_circle(px, py, 2 * (ar + br), 2 * longint'(p.bx),
                                      2 * longint'(p.by));
            end
            MODE_CIRC_RECT: begin
                // A centre inside either band of the rectangle means the
                // nearest point is on an edge, so the circle acts as a square.
                // Otherwise the nearest point is one of the four corners.
                if ((px > rect_b.l && px < rect_b.r) || (py > rect_b.t && py < rect_b.b)) begin
                    hit = edges_overlap(edges_of(ax, ay, 2 * ar, 2 * ar), rect_b);
                end else begin
                    hit = point_in_circle(px, py, 2 * ar, rect_b.l, rect_b.t) ||
                          point_in_circle(px, py, 2 * ar, rect_b.r, rect_b.t) ||
                          point_in_circle(px, py, 2 * ar, rect_b.l, rect_b.b) ||
                          point_in_circle(px, py, 2 * ar, rect_b.r, rect_b.b);
                end
            end
            default: begin
                hit = 1'b0;
            end
        endcase
        return hit;
    endfunction

    // ------------------------------------------------------------------
    // Request building and driving
    // ------------------------------------------------------------------

    function automatic shape_pair_t make_pair(int mode, int ax, int ay, int aw, int ah,
                                              int ar, int bx, int by, int bw, int bh,
                                              int br);
        shape_pair_t p;
        p.mode = mode[2:0];
        p.ax   = ax[CW-1:0];
        p.ay   = ay[CW-1:0];
        p.aw   = aw[CW-1:0];
        p.ah   = ah[CW-1:0];
        p.ar   = ar[CW-2:0];
        p.bx   = bx[CW-1:0];
        p.by   = by[CW-1:0];
        p.bw   = bw[CW-1:0];
        p.bh   = bh[CW-1:0];
        p.br   = br[CW-2:0];
        return p;
    endfunction

    // Fields go into tdata from bit 0 up in the order of the port comment.
    function automatic logic [TDATA_W-1:0] pack_pair(shape_pair_t p);
        return {{(TDATA_W - 10 * CW + 2){1'b0}}, p.br, p.bh, p.bw, p.by, p.bx,
                p.ar, p.ah, p.aw, p.ay, p.ax};
    endfunction

    // Idle length for either side: none at level 0, otherwise often none,
    // sometimes a short gap and now and then a long stretch.
    function automatic int unsigned pick_gap(int level);
        int unsigned roll;
        roll = $urandom_range(99);
        if (level == 0) begin
            return 0;
        end
        if (roll < ((level == 1) ? 75 : 45)) begin
            return 0;
        end
        if (roll < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Presents one request and returns in the step of its handshake, with
    // tvalid still high. The next call either keeps it high with new data or
    // lowers it for a gap, so tvalid never sees two assignments in one step.
    task automatic send_pair(input shape_pair_t p);
        int unsigned gap;
        gap = pick_gap(idle_level);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_pair(p);
        s_tuser  <= p.mode;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        pending_hits.push_back(predict_hit(p));
    endtask

    // ------------------------------------------------------------------
    // Receiver side: back-pressure and result checking
    // ------------------------------------------------------------------

    // tready drops for stalls of random length while idling is enabled.
    always @(posedge i_clk) begin
        int unsigned g;
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            g = pick_gap(idle_level);
            if (g == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready   <= 1'b0;
                stall_left <= g - 1;
            end
        end
    end

    // Every accepted result byte must match the oldest prediction, with the
    // zero fill above the hit flag included.
    always @(posedge i_clk) begin
        logic [7:0] want_byte;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_hits.size() == 0) begin
                $display("%0t: result with no request waiting, expected none, got %02h",
                         $time, m_tdata);
                error_count++;
            end else begin
                want_byte = {7'b0, pending_hits.pop_front()};
                if (m_tdata !== want_byte) begin
                    $display("%0t: hit mismatch, expected %02h, got %02h",
                             $time, want_byte, m_tdata);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_shape_overlap_test NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed tests. One unit of Q12.4 is 16 counts.
    // ------------------------------------------------------------------

    // Point inside, exactly on an edge (strict, so no hit), just inside an
    // odd-sized rectangle whose edge sits on a half count, and the extremes.
    task automatic test_point_rect();
        send_pair(make_pair(MODE_PT_RECT, 0, 0, 0, 0, 0, 0, 0, 16, 16, 0));
        send_pair(make_pair(MODE_PT_RECT, 16, 0, 0, 0, 0, 0, 0, 32, 32, 0));
        send_pair(make_pair(MODE_PT_RECT, 16, 0, 0, 0, 0, 0, 0, 33, 33, 0));
        send_pair(make_pair(MODE_PT_RECT, -32768, 32767, 65535, 65535, 32767,
                            -32768, 32767, 65535, 65535, 32767));
    endtask

    // Overlap, shared edge, a zero-width rectangle, and the largest
    // rectangles at opposite corners whose edges just meet.
    task automatic test_rect_rect();
        send_pair(make_pair(MODE_RECT_RECT, 0, 0, 32, 32, 0, 16, 16, 32, 32, 0));
        send_pair(make_pair(MODE_RECT_RECT, 0, 0, 32, 32, 0, 32, 0, 32, 32, 0));
        send_pair(make_pair(MODE_RECT_RECT, 0, 0, 0, 16, 0, 0, 0, 32, 32, 0));
        send_pair(make_pair(MODE_RECT_RECT, 32767, 32767, 65535, 65535, 0,
                            -32768, -32768, 65535, 65535, 0));
    endtask

    // Inside, exactly on the circle (3-4-5 triangle), a zero radius on its
    // own centre, and the largest radius at the coordinate extremes.
    task automatic test_point_circle();
        send_pair(make_pair(MODE_PT_CIRC, 0, 0, 0, 0, 80, 16, 16, 0, 0, 0));
        send_pair(make_pair(MODE_PT_CIRC, 0, 0, 0, 0, 80, 48, 64, 0, 0, 0));
        send_pair(make_pair(MODE_PT_CIRC, 100, 100, 0, 0, 0, 100, 100, 0, 0, 0));
        send_pair(make_pair(MODE_PT_CIRC, -32768, -32768, 0, 0, 32767,
                            -2, -32768, 0, 0, 0));
    endtask

    // Touching circles give no hit; one count closer they overlap. Then the
    // largest radii, far apart and just overlapping.
    task automatic test_circle_circle();
        send_pair(make_pair(MODE_CIRC_CIRC, 0, 0, 0, 0, 16, 32, 0, 0, 0, 16));
        send_pair(make_pair(MODE_CIRC_CIRC, 0, 0, 0, 0, 16, 31, 0, 0, 0, 16));
        send_pair(make_pair(MODE_CIRC_CIRC, -32768, -32768, 0, 0, 32767,
                            32767, 32767, 0, 0, 32767));
        send_pair(make_pair(MODE_CIRC_CIRC, -32768, 0, 0, 0, 32767,
                            32765, 0, 0, 0, 32767));
    endtask

    // Rectangle B spans -32..32 on both axes. Centres in the x band and the
    // y band take the square path; diagonal centres take the corner path,
    // once just reaching the corner and once just short of it.
    task automatic test_circle_rect();
        send_pair(make_pair(MODE_CIRC_RECT, 0, 40, 0, 0, 10, 0, 0, 64, 64, 0));
        send_pair(make_pair(MODE_CIRC_RECT, 0, 48, 0, 0, 16, 0, 0, 64, 64, 0));
        send_pair(make_pair(MODE_CIRC_RECT, 48, 0, 0, 0, 20, 0, 0, 64, 64, 0));
        send_pair(make_pair(MODE_CIRC_RECT, 40, 40, 0, 0, 12, 0, 0, 64, 64, 0));
        send_pair(make_pair(MODE_CIRC_RECT, 40, 40, 0, 0, 11, 0, 0, 64, 64, 0));
        send_pair(make_pair(MODE_CIRC_RECT, 0, 0, 0, 0, 0, 0, 0, 64, 64, 0));
    endtask

    // The spare mode codes never hit, even for shapes that plainly overlap.
    task automatic test_unused_modes();
        send_pair(make_pair(5, 0, 0, 32, 32, 16, 0, 0, 32, 32, 16));
        send_pair(make_pair(6, 0, 0, 32, 32, 16, 0, 0, 32, 32, 16));
        send_pair(make_pair(7, 0, 0, 32, 32, 16, 0, 0, 32, 32, 16));
    endtask

    // ------------------------------------------------------------------
    // Random test
    // ------------------------------------------------------------------

    // Mostly shapes placed near each other with moderate sizes, so hits and
    // misses both come often; the rest use fully random fields so that every
    // bit of every field is exercised.
    function automatic shape_pair_t random_pair();
        shape_pair_t p;
        int          mode;
        int          cx;
        int          cy;
        mode = ($urandom_range(99) < 90) ? $urandom_range(0, 4) : $urandom_range(5, 7);
        if ($urandom_range(99) < 20) begin
            p = make_pair(mode, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            cx = int'($urandom_range(0, 8191)) - 4096;
            cy = int'($urandom_range(0, 8191)) - 4096;
            p  = make_pair(mode, cx, cy,
                           $urandom_range(0, 1023), $urandom_range(0, 1023),
                           $urandom_range(0, 511),
                           cx + int'($urandom_range(0, 1535)) - 768,
                           cy + int'($urandom_range(0, 1535)) - 768,
                           $urandom_range(0, 1023), $urandom_range(0, 1023),
                           $urandom_range(0, 511));
        end
        return p;
    endfunction

    // Three stretches: no idling, light idling and heavy idling, so gaps and
    // stalls land on every stage of the pipeline.
    task automatic test_random_pairs();
        idle_level = 0;
        repeat (150) send_pair(random_pair());
        idle_level = 1;
        repeat (300) send_pair(random_pair());
        idle_level = 2;
        repeat (300) send_pair(random_pair());
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_point_rect();
        test_rect_rect();
        test_point_circle();
        test_circle_circle();
        test_circle_rect();
        test_unused_modes();
        test_random_pairs();

        // Stop sending, let the receiver run freely and wait for every
        // outstanding result; the watchdog covers a result that never comes.
        s_tvalid   <= 1'b0;
        idle_level = 0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("tb_shape_overlap_test OK");
        end else begin
            $display("tb_shape_overlap_test NOT OK");
        end
        $finish;
    end

endmodule
